// File: hdl/mmcpu_pkg.sv
// package for the memory-to-memory cpu step block
// holds opcode, action and status codes and default sizes; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package mmcpu_pkg;
  localparam int MemWordsDefault = 4096;
  localparam int WordBitsDefault = 16;
  localparam int AddrBits = 12;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_READ = 2'd1;
  localparam logic [1:0] ACT_EXEC = 2'd2;
  localparam logic [1:0] ACT_RESTART = 2'd3;

  localparam logic [1:0] ST_RUN = 2'd0;
  localparam logic [1:0] ST_HALT = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;
  localparam logic [1:0] ST_BADOP = 2'd3;

  localparam logic [4:0] OP_HALT = 5'd0;
  localparam logic [4:0] OP_MOV = 5'd1;
  localparam logic [4:0] OP_MOVI = 5'd2;
  localparam logic [4:0] OP_INC = 5'd3;
  localparam logic [4:0] OP_ADD = 5'd4;
  localparam logic [4:0] OP_ADDI = 5'd5;
  localparam logic [4:0] OP_SUB = 5'd6;
  localparam logic [4:0] OP_SUBI = 5'd7;
  localparam logic [4:0] OP_MUL = 5'd8;
  localparam logic [4:0] OP_MULI = 5'd9;
  localparam logic [4:0] OP_DIV = 5'd10;
  localparam logic [4:0] OP_DIVI = 5'd11;
  localparam logic [4:0] OP_NEG = 5'd12;
  localparam logic [4:0] OP_XCHG = 5'd13;
  localparam logic [4:0] OP_AND = 5'd14;
  localparam logic [4:0] OP_ANDI = 5'd15;
  localparam logic [4:0] OP_OR = 5'd16;
  localparam logic [4:0] OP_ORI = 5'd17;
  localparam logic [4:0] OP_XOR = 5'd18;
  localparam logic [4:0] OP_XORI = 5'd19;
  localparam logic [4:0] OP_NOT = 5'd20;
  localparam logic [4:0] OP_JMP = 5'd21;
  localparam logic [4:0] OP_NOP = 5'd22;
  localparam logic [4:0] OP_CMP = 5'd23;
  localparam logic [4:0] OP_CMPI = 5'd24;
  localparam logic [4:0] OP_INT = 5'd25;
endpackage
`default_nettype wire

// File: hdl/memory_to_memory_cpu_step.sv
// memory-to-memory cpu step: word memory, program counter, stop code
// sequencer around one memory port, one alu and a bit-serial divider
// a new input transfer is taken only in idle, once the result of the last one
// has been put out; the single memory port (one access a cycle) and the
// divider (16 steps at the default width) set the pace of execute items.
// synchronous reset clears counter, stop code and start address; memory is
// undefined until written and gets no clearing.
// depends on mmcpu_pkg
`timescale 1ns / 1ps
`default_nettype none
module memory_to_memory_cpu_step
  import mmcpu_pkg::*;
#(
  parameter int MEM_WORDS = MemWordsDefault,
  parameter int WORD_BITS = WordBitsDefault
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire  [1:0]           action,
  input  wire  [AddrBits-1:0]  word_address,
  input  wire  [WORD_BITS-1:0] load_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic [WORD_BITS-1:0] read_data,
  output logic [AddrBits-1:0]  counter_now,
  output logic [1:0]           run_status,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire  [AddrBits-1:0]  cfg_data
);
  localparam int AW = $clog2(MEM_WORDS);
  localparam int CW = (AW > AddrBits) ? AW : AddrBits;

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD_OP = 4'd1;
  localparam logic [3:0] S_RD_O1 = 4'd2;
  localparam logic [3:0] S_RD_O2 = 4'd3;
  localparam logic [3:0] S_RD_DV = 4'd4;
  localparam logic [3:0] S_RD_SV = 4'd5;
  localparam logic [3:0] S_ALU = 4'd6;
  localparam logic [3:0] S_DIV = 4'd7;
  localparam logic [3:0] S_WR = 4'd8;
  localparam logic [3:0] S_WR2 = 4'd9;
  localparam logic [3:0] S_OUT = 4'd10;
  localparam logic [3:0] S_RD_WAIT = 4'd11;
  localparam logic [3:0] S_WAIT = 4'd12;

  logic [WORD_BITS-1:0] mem [MEM_WORDS];
  logic [WORD_BITS-1:0] mem_q;
  logic [AW-1:0] mem_addr;
  logic mem_we;
  logic [WORD_BITS-1:0] mem_wd;

  logic [3:0] state;
  logic [3:0] ret_state;
  logic [AW-1:0] pc;
  logic [1:0] stop;
  logic [AddrBits-1:0] start_address;
  logic [4:0] opc;
  logic bad_op;
  logic [WORD_BITS-1:0] o1, o2, dv, sv, res;
  logic [WORD_BITS-1:0] rd_word;
  logic [AW-1:0] addr_in;
  logic [4:0] div_cnt;
  logic [WORD_BITS-1:0] quo, rem;
  logic [WORD_BITS:0] rem_try;
  logic [WORD_BITS-1:0] rhs;
  logic is_imm;
  logic [WORD_BITS-1:0] prod;

  assign cfg_ready = (state == S_IDLE);
  assign in_stall = (state != S_IDLE);

  // memory with registered read data
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    mem_q <= mem[mem_addr];
  end

  // immediate forms take the second operand word as the value
  always_comb begin
    case (opc)
      OP_MOVI, OP_ADDI, OP_SUBI, OP_MULI, OP_DIVI, OP_ANDI, OP_ORI, OP_XORI,
      OP_CMPI: is_imm = 1'b1;
      default: is_imm = 1'b0;
    endcase
  end
  assign rhs = is_imm ? o2 : sv;
  assign prod = dv * rhs;
  assign rem_try = {rem, quo[WORD_BITS-1]} - {1'b0, rhs};

  // memory port address and write control
  always_comb begin
    mem_addr = pc;
    mem_we = 1'b0;
    mem_wd = res;
    case (state)
      S_IDLE: begin
        mem_addr = AW'(word_address);
        mem_we = in_valid && (action == ACT_LOAD);
        mem_wd = load_data;
        if (in_valid && action == ACT_EXEC) mem_addr = pc;
      end
      S_RD_OP: mem_addr = AW'(pc + AW'(1));
      S_RD_O1: mem_addr = AW'(pc + AW'(2));
      S_RD_O2: mem_addr = o1[AW-1:0];
      S_RD_DV: mem_addr = o2[AW-1:0];
      S_WR: begin
        mem_addr = o1[AW-1:0];
        mem_we = 1'b1;
      end
      S_WR2: begin
        mem_addr = o2[AW-1:0];
        mem_we = 1'b1;
        mem_wd = dv;
      end
      default: mem_addr = addr_in;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc <= '0;
      stop <= ST_RUN;
      start_address <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cfg_valid) start_address <= cfg_data;
          if (in_valid) begin
            addr_in <= AW'(word_address);
            rd_word <= '0;
            case (action)
              ACT_READ: state <= S_RD_WAIT;
              ACT_EXEC: state <= (stop == ST_RUN) ? S_RD_OP : S_OUT;
              ACT_RESTART: begin
                pc <= AW'(start_address);
                stop <= ST_RUN;
                state <= S_OUT;
              end
              default: state <= S_OUT;
            endcase
          end
        end
        S_RD_WAIT: state <= S_WAIT;
        S_WAIT: begin
          rd_word <= mem_q;
          state <= S_OUT;
        end
        S_RD_OP: begin
          opc <= mem_q[4:0];
          bad_op <= (mem_q > WORD_BITS'(25));
          state <= S_RD_O1;
        end
        S_RD_O1: begin
          o1 <= mem_q;
          state <= S_RD_O2;
        end
        S_RD_O2: begin
          o2 <= mem_q;
          state <= S_RD_DV;
        end
        S_RD_DV: begin
          dv <= mem_q;
          state <= S_RD_SV;
        end
        S_RD_SV: begin
          sv <= mem_q;
          state <= S_ALU;
        end
        S_ALU: begin
          state <= S_OUT;
          ret_state <= S_OUT;
          if (bad_op) begin
            stop <= ST_BADOP;
          end else begin
            case (opc)
              OP_HALT: stop <= ST_HALT;
              OP_JMP: pc <= o1[AW-1:0];
              OP_NOP: pc <= AW'(pc + AW'(1));
              OP_INT: pc <= AW'(pc + AW'(2));
              OP_INC: begin
                res <= dv + WORD_BITS'(1);
                pc <= AW'(pc + AW'(2));
                state <= S_WR;
              end
              OP_NEG: begin
                res <= WORD_BITS'(0) - dv;
                pc <= AW'(pc + AW'(2));
                state <= S_WR;
              end
              OP_NOT: begin
                res <= ~dv;
                pc <= AW'(pc + AW'(2));
                state <= S_WR;
              end
              OP_XCHG: begin
                res <= sv;
                ret_state <= S_WR2;
                pc <= AW'(pc + AW'(3));
                state <= S_WR;
              end
              OP_DIV, OP_DIVI: begin
                if (rhs == '0) begin
                  stop <= ST_DIVZ;
                end else begin
                  quo <= dv;
                  rem <= '0;
                  div_cnt <= 5'(WORD_BITS);
                  state <= S_DIV;
                end
              end
              default: begin
                case (opc)
                  OP_MOV, OP_MOVI: res <= rhs;
                  OP_ADD, OP_ADDI: res <= dv + rhs;
                  OP_SUB, OP_SUBI: res <= dv - rhs;
                  OP_MUL, OP_MULI: res <= prod;
                  OP_AND, OP_ANDI: res <= dv & rhs;
                  OP_OR, OP_ORI: res <= dv | rhs;
                  OP_XOR, OP_XORI: res <= dv ^ rhs;
                  default: res <= (dv == rhs) ? WORD_BITS'(1) : WORD_BITS'(0);
                endcase
                pc <= AW'(pc + AW'(3));
                state <= S_WR;
              end
            endcase
          end
        end
        // restoring divide, one quotient bit a cycle
        S_DIV: begin
          if (rem_try[WORD_BITS]) begin
            rem <= {rem[WORD_BITS-2:0], quo[WORD_BITS-1]};
            quo <= {quo[WORD_BITS-2:0], 1'b0};
          end else begin
            rem <= rem_try[WORD_BITS-1:0];
            quo <= {quo[WORD_BITS-2:0], 1'b1};
          end
          div_cnt <= div_cnt - 5'd1;
          if (div_cnt == 5'd1) begin
            res <= rem_try[WORD_BITS] ? {quo[WORD_BITS-2:0], 1'b0}
                                      : {quo[WORD_BITS-2:0], 1'b1};
            pc <= AW'(pc + AW'(3));
            state <= S_WR;
          end
        end
        S_WR: state <= ret_state;
        S_WR2: state <= S_OUT;
        // result register only changes once the previous transfer is gone
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            read_data <= rd_word;
            counter_now <= AddrBits'(CW'(pc));
            run_status <= stop;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: tb/memory_to_memory_cpu_step_tb.sv
// testbench for the memory-to-memory cpu step block
// drives load, read, execute and restart transfers and checks every result
// against an in-bench model of the cpu; depends on mmcpu_pkg and the block
`timescale 1ns / 1ps
module memory_to_memory_cpu_step_tb;
  import mmcpu_pkg::*;

  typedef struct packed {
    logic [15:0] rd;
    logic [11:0] pc;
    logic [1:0]  st;
  } cpu_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  action = ACT_LOAD;
  logic [11:0] word_address = '0;
  logic [15:0] load_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] read_data;
  logic [11:0] counter_now;
  logic [1:0]  run_status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [11:0] cfg_data = '0;

  // model state
  logic [15:0] cpu_mem [4096];
  bit          mem_loaded [4096];
  logic [11:0] cpu_pc;
  logic [1:0]  cpu_stop;
  logic [11:0] cpu_start;

  cpu_result_t result_q [$];
  int          mismatches = 0;
  int          items_sent = 0;
  int          execs_sent = 0;
  int          start_writes = 0;
  int          stall_left = 0;
  int          idle_cycles = 0;
  bit          no_gaps = 1'b0;

  memory_to_memory_cpu_step u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .word_address(word_address), .load_data(load_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_data(read_data), .counter_now(counter_now), .run_status(run_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // one instruction on the model
  task automatic step_cpu();
    logic [11:0] pc, p1, p2, d;
    logic [15:0] op, o1, o2, dv, sv, rhs, wr;
    bit          do_wr, imm;
    pc = cpu_pc;
    p1 = pc + 12'd1;
    p2 = pc + 12'd2;
    op = cpu_mem[pc];
    o1 = cpu_mem[p1];
    o2 = cpu_mem[p2];
    d = o1[11:0];
    dv = cpu_mem[d];
    sv = cpu_mem[o2[11:0]];
    do_wr = 1'b1;
    wr = '0;
    imm = op == OP_MOVI || op == OP_ADDI || op == OP_SUBI || op == OP_MULI ||
          op == OP_DIVI || op == OP_ANDI || op == OP_ORI || op == OP_XORI ||
          op == OP_CMPI;
    rhs = imm ? o2 : sv;
    if (op > 16'd25) begin
      cpu_stop = ST_BADOP;
      return;
    end
    case (op[4:0])
      OP_HALT: begin
        cpu_stop = ST_HALT;
        return;
      end
      OP_INC: begin wr = dv + 16'd1; cpu_pc = p2; end
      OP_NEG: begin wr = 16'd0 - dv; cpu_pc = p2; end
      OP_NOT: begin wr = ~dv; cpu_pc = p2; end
      OP_JMP: begin do_wr = 0; cpu_pc = d; end
      OP_NOP: begin do_wr = 0; cpu_pc = p1; end
      OP_INT: begin do_wr = 0; cpu_pc = p2; end
      OP_XCHG: begin
        cpu_mem[d] = sv;
        mem_loaded[d] = 1;
        cpu_mem[o2[11:0]] = dv;
        mem_loaded[o2[11:0]] = 1;
        do_wr = 0;
        cpu_pc = pc + 12'd3;
      end
      default: begin
        case (op[4:0])
          OP_MOV, OP_MOVI: wr = rhs;
          OP_ADD, OP_ADDI: wr = dv + rhs;
          OP_SUB, OP_SUBI: wr = dv - rhs;
          OP_MUL, OP_MULI: wr = dv * rhs;
          OP_DIV, OP_DIVI: begin
            if (rhs == 0) begin
              cpu_stop = ST_DIVZ;
              return;
            end
            wr = dv / rhs;
          end
          OP_AND, OP_ANDI: wr = dv & rhs;
          OP_OR, OP_ORI: wr = dv | rhs;
          OP_XOR, OP_XORI: wr = dv ^ rhs;
          default: wr = (dv == rhs) ? 16'd1 : 16'd0;
        endcase
        cpu_pc = pc + 12'd3;
      end
    endcase
    if (do_wr) begin
      cpu_mem[d] = wr;
      mem_loaded[d] = 1;
    end
  endtask

  // expected result of one item, model state updated
  task automatic predict_item(input logic [1:0] act, input logic [11:0] addr,
                              input logic [15:0] data, output cpu_result_t r);
    r.rd = '0;
    case (act)
      ACT_LOAD: begin
        cpu_mem[addr] = data;
        mem_loaded[addr] = 1;
      end
      ACT_READ: r.rd = cpu_mem[addr];
      ACT_EXEC: if (cpu_stop == ST_RUN) step_cpu();
      default: begin
        cpu_pc = cpu_start;
        cpu_stop = ST_RUN;
      end
    endcase
    r.pc = cpu_pc;
    r.st = cpu_stop;
  endtask

  // send one item and wait for its transfer
  task automatic send_item(input logic [1:0] act, input logic [11:0] addr,
                           input logic [15:0] data);
    cpu_result_t r;
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    predict_item(act, addr, data, r);
    result_q.push_back(r);
    in_valid <= 1'b1;
    action <= act;
    word_address <= addr;
    load_data <= data;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic load_word(input logic [11:0] addr, input logic [15:0] data);
    send_item(ACT_LOAD, addr, data);
  endtask

  task automatic fill_word(input logic [11:0] addr);
    if (!mem_loaded[addr]) load_word(addr, 16'($urandom));
  endtask

  task automatic read_word(input logic [11:0] addr);
    fill_word(addr);
    send_item(ACT_READ, addr, 16'($urandom));
  endtask

  // every word the instruction touches must hold a loaded value
  task automatic exec_item();
    logic [11:0] pc;
    if (cpu_stop == ST_RUN) begin
      pc = cpu_pc;
      fill_word(pc);
      fill_word(pc + 12'd1);
      fill_word(pc + 12'd2);
      fill_word(cpu_mem[pc + 12'd1][11:0]);
      fill_word(cpu_mem[pc + 12'd2][11:0]);
    end
    send_item(ACT_EXEC, 12'($urandom), 16'($urandom));
    execs_sent++;
  endtask

  task automatic restart_cpu();
    send_item(ACT_RESTART, 12'($urandom), 16'($urandom));
  endtask

  // hold the sender until all results are back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_start(input logic [11:0] v);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cpu_start = v;
    start_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic report(input string what, input logic [15:0] exp_v,
                        input logic [15:0] got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %h got %h at %0t", what, exp_v, got_v, $realtime);
  endtask

  // result check, receiver stall draw and watchdog
  always @(posedge clk) begin : result_check
    cpu_result_t e;
    bit moved;
    if (!rst) begin
      moved = (in_valid && !in_stall) || (cfg_valid && cfg_ready);
      if (out_valid && !out_stall) begin
        moved = 1;
        if (result_q.size() == 0) begin
          report("unexpected result", '0, read_data);
        end else begin
          e = result_q.pop_front();
          if (read_data !== e.rd) report("read_data", e.rd, read_data);
          if (counter_now !== e.pc)
            report("counter_now", 16'(e.pc), 16'(counter_now));
          if (run_status !== e.st)
            report("run_status", 16'(e.st), 16'(run_status));
        end
        stall_left = no_gaps ? 0 : $urandom_range(0, 9);
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= 5000) begin
        $display("timeout: no transfer for %0d cycles", idle_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // load and read at the address and data extremes
  task automatic test_load_read();
    load_word(12'd0, 16'h0000);
    load_word(12'd4095, 16'hFFFF);
    read_word(12'd0);
    read_word(12'd4095);
    load_word(12'd0, 16'hFFFF);
    read_word(12'd0);
  endtask

  // top start address, counter and operand wrap
  task automatic test_wrap();
    write_start(12'd4095);
    restart_cpu();
    load_word(12'd4095, 16'(OP_INC));
    load_word(12'd0, 16'hF001);
    load_word(12'd1, 16'hFFFF);
    exec_item();
    read_word(12'd1);
    write_start(12'd0);
    restart_cpu();
  endtask

  // halt, divide by zero, bad opcode, execute while stopped
  task automatic test_stops();
    write_start(12'd100);
    restart_cpu();
    load_word(12'd100, 16'(OP_DIVI));
    load_word(12'd101, 16'd200);
    load_word(12'd102, 16'd0);
    load_word(12'd200, 16'd5);
    exec_item();
    exec_item();
    read_word(12'd200);
    restart_cpu();
    load_word(12'd100, 16'(OP_DIV));
    load_word(12'd102, 16'd201);
    load_word(12'd201, 16'd0);
    exec_item();
    restart_cpu();
    load_word(12'd100, 16'(OP_HALT));
    exec_item();
    restart_cpu();
    load_word(12'd100, 16'hFFFF);
    exec_item();
    restart_cpu();
    load_word(12'd100, 16'd26);
    exec_item();
    restart_cpu();
  endtask

  // short random programs over a small data window, plus noise items
  task automatic test_random_programs();
    logic [11:0] base, at, nxt;
    logic [15:0] op, a, b;
    int n, len;
    while (items_sent < 1250) begin
      no_gaps = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 3) == 0) write_start(12'($urandom));
      base = 12'($urandom);
      at = cpu_start;
      n = $urandom_range(2, 8);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 19))
          0: op = 16'(OP_HALT);
          1: op = 16'($urandom_range(26, 65535));
          default: op = 16'($urandom_range(1, 25));
        endcase
        len = (op == OP_NOP) ? 1 :
              (op == OP_INC || op == OP_NEG || op == OP_NOT ||
               op == OP_JMP || op == OP_INT) ? 2 : 3;
        a = {4'($urandom_range(0, 15)), 12'(base + $urandom_range(0, 7))};
        if (op == OP_JMP) a = {4'($urandom_range(0, 15)), cpu_start};
        b = {4'($urandom_range(0, 15)), 12'(base + $urandom_range(0, 7))};
        if (op == OP_MOVI || op == OP_ADDI || op == OP_SUBI || op == OP_MULI ||
            op == OP_DIVI || op == OP_ANDI || op == OP_ORI || op == OP_XORI ||
            op == OP_CMPI || op == OP_INT)
          b = ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom);
        load_word(at, op);
        if (len > 1) load_word(at + 12'd1, a);
        if (len > 2) load_word(at + 12'd2, b);
        at = at + 12'(len);
      end
      for (int i = 0; i < 8; i++)
        load_word(base + 12'(i), ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3))
                                                             : 16'($urandom));
      restart_cpu();
      for (int i = 0; i < n + 2; i++) begin
        exec_item();
        if ($urandom_range(0, 3) == 0) read_word(base + 12'($urandom_range(0, 7)));
      end
      // noise
      repeat ($urandom_range(0, 4)) begin
        nxt = 12'($urandom);
        case ($urandom_range(0, 3))
          0: load_word(nxt, 16'($urandom));
          1: read_word(nxt);
          2: exec_item();
          default: restart_cpu();
        endcase
      end
    end
  endtask

  initial begin
    cpu_pc = '0;
    cpu_stop = ST_RUN;
    cpu_start = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_load_read();
    test_wrap();
    test_stops();
    test_random_programs();
    drain();
    repeat (40) @(posedge clk);
    $display("covered %0d items, %0d execute items, %0d start address writes",
             items_sent, execs_sent, start_writes);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
